@@ design/bfs_adjacency_matrix_macros.svh @@
// ----------------------------------------------------------------------------
// bfs_adjacency_matrix_macros
// Assertion macros shared by the breadth-first search block.
// ----------------------------------------------------------------------------
`ifndef BFS_ADJACENCY_MATRIX_MACROS_SVH
`define BFS_ADJACENCY_MATRIX_MACROS_SVH

`ifndef SYNTHESIS
`define BFS_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed: cond |-> prop");
`define BFS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed: cond |=> prop");
`else
`define BFS_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define BFS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

@@ design/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg
// Constants and controller/datapath interface types for the BFS block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfs_pkg;

    localparam int NODES       = 16;
    localparam int WEIGHT_BITS = 8;

    localparam int NODE_FIELD_W   = 4;
    localparam int WEIGHT_FIELD_W = 8;
    localparam int DIST_W         = 12;

    localparam int NODE_W = $clog2(NODES);
    localparam int QPTR_W = NODE_W + 1;
    localparam int CELLS  = NODES * NODES;
    localparam int ADDR_W = 2 * NODE_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic load_a;
        logic load_b;
        logic init;
        logic deq;
        logic scan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic q_ready;
        logic col_last;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ design/bfs_ram.sv @@
// ----------------------------------------------------------------------------
// bfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/bfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfs_ctrl
// Sequencer for matrix clear, edge load, search and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_cmd,
    output logic               o_in_ready,
    input  wire bfs_pkg::t_stat i_stat,
    output bfs_pkg::t_cmd      o_cmd
);

    import bfs_pkg::*;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_LOAD_A = 4'd2;
    localparam logic [3:0] ST_LOAD_B = 4'd3;
    localparam logic [3:0] ST_INIT   = 4'd4;
    localparam logic [3:0] ST_DEQ    = 4'd5;
    localparam logic [3:0] ST_SCAN   = 4'd6;
    localparam logic [3:0] ST_DRAIN  = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_cmd == OP_SEARCH) ? ST_INIT : ST_LOAD_A;
                end
            end
            ST_LOAD_A: begin
                o_cmd.load_a = 1'b1;
                n_state = ST_LOAD_B;
            end
            ST_LOAD_B: begin
                o_cmd.load_b = 1'b1;
                n_state = ST_IDLE;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state = ST_DEQ;
            end
            ST_DEQ: begin
                if (i_stat.q_ready) begin
                    o_cmd.deq = 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.col_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DEQ;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/bfs_dp.sv @@
// ----------------------------------------------------------------------------
// bfs_dp
// Datapath: adjacency RAM, per-node state, visit queue and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire bfs_pkg::t_cmd                        i_cmd_bus,
    output bfs_pkg::t_stat                            o_stat,
    input  wire logic [bfs_pkg::NODE_FIELD_W-1:0]     i_from_node,
    input  wire logic [bfs_pkg::NODE_FIELD_W-1:0]     i_to_node,
    input  wire logic [bfs_pkg::WEIGHT_FIELD_W-1:0]   i_weight,
    input  wire logic [bfs_pkg::NODE_FIELD_W-1:0]     i_root_node,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic      [bfs_pkg::NODE_FIELD_W-1:0]     o_node_id,
    output logic                                      o_reached,
    output logic      [bfs_pkg::DIST_W-1:0]           o_distance,
    output logic                                      o_has_parent,
    output logic      [bfs_pkg::NODE_FIELD_W-1:0]     o_parent,
    output logic                                      o_last
);

    import bfs_pkg::*;

    logic [NODE_FIELD_W-1:0]   r_from;
    logic [NODE_FIELD_W-1:0]   r_to;
    logic [WEIGHT_BITS-1:0]    r_weight;
    logic [NODE_FIELD_W-1:0]   r_root;

    logic [ADDR_W-1:0]         r_clr_cnt;
    logic [NODES-1:0]          r_reached;
    logic [NODES-1:0]          r_has_parent;
    logic [DIST_W-1:0]         r_dist   [NODES];
    logic [NODE_W-1:0]         r_parent [NODES];
    logic [NODE_W-1:0]         r_fifo   [NODES];
    logic [QPTR_W-1:0]         r_head;
    logic [QPTR_W-1:0]         r_tail;
    logic [NODE_W-1:0]         r_cur;
    logic [DIST_W-1:0]         r_base;
    logic [NODE_W-1:0]         r_col;
    logic                      r_eval_valid;
    logic [NODE_W-1:0]         r_eval_col;
    logic [NODE_W-1:0]         r_emit_idx;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [WEIGHT_BITS-1:0]    ram_wdata;
    logic [WEIGHT_BITS-1:0]    ram_rdata;

    logic                      load_ok;
    logic                      root_ok;
    logic [NODE_W-1:0]         head_node;
    logic [NODE_W-1:0]         rd_idx;
    logic [DIST_W-1:0]         rd_dist;
    logic                      hit;
    logic [DIST_W:0]           sum;
    logic [DIST_W-1:0]         new_dist;
    logic                      enq_ok;
    logic                      emit_hp;

    assign load_ok = ({1'b0, r_from} < (NODE_FIELD_W+1)'(NODES))
                  && ({1'b0, r_to} < (NODE_FIELD_W+1)'(NODES));
    assign root_ok = ({1'b0, r_root} < (NODE_FIELD_W+1)'(NODES));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_cnt;
        ram_wdata = '0;
        priority if (i_cmd_bus.clr_step) begin
            ram_we = 1'b1;
        end else if (i_cmd_bus.load_a) begin
            ram_we    = load_ok;
            ram_waddr = {r_from[NODE_W-1:0], r_to[NODE_W-1:0]};
            ram_wdata = r_weight;
        end else if (i_cmd_bus.load_b) begin
            ram_we    = load_ok;
            ram_waddr = {r_to[NODE_W-1:0], r_from[NODE_W-1:0]};
            ram_wdata = r_weight;
        end
    end

    bfs_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (CELLS)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr ({r_cur, r_col}),
        .o_rdata (ram_rdata)
    );

    assign head_node = r_fifo[r_head[NODE_W-1:0]];
    assign rd_idx    = i_cmd_bus.emit ? r_emit_idx : head_node;
    assign rd_dist   = r_dist[rd_idx];

    assign hit      = r_eval_valid && (ram_rdata != '0) && !r_reached[r_eval_col];
    assign sum      = {1'b0, r_base} + (DIST_W+1)'(ram_rdata);
    assign new_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    assign enq_ok   = r_tail < QPTR_W'(NODES);
    assign emit_hp  = r_reached[r_emit_idx] && r_has_parent[r_emit_idx];

    assign o_stat.clr_last  = (r_clr_cnt == ADDR_W'(CELLS - 1));
    assign o_stat.q_ready   = (r_head < r_tail) && (r_head < QPTR_W'(NODES));
    assign o_stat.col_last  = (r_col == NODE_W'(NODES - 1));
    assign o_stat.emit_last = (r_emit_idx == NODE_W'(NODES - 1));
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= '0;
            r_reached    <= '0;
            r_has_parent <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_col        <= '0;
            r_eval_valid <= 1'b0;
            r_emit_idx   <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cmd_bus.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            r_eval_valid <= i_cmd_bus.scan;
            if (i_cmd_bus.init) begin
                r_reached    <= root_ok ? (NODES'(1) << r_root[NODE_W-1:0]) : '0;
                r_has_parent <= '0;
                r_head       <= '0;
                r_tail       <= root_ok ? QPTR_W'(1) : '0;
                r_emit_idx   <= '0;
            end else if (hit) begin
                r_reached[r_eval_col]    <= 1'b1;
                r_has_parent[r_eval_col] <= 1'b1;
                if (enq_ok) begin
                    r_tail <= r_tail + 1'b1;
                end
            end
            if (i_cmd_bus.deq) begin
                r_head <= r_head + 1'b1;
                r_col  <= '0;
            end else if (i_cmd_bus.scan) begin
                r_col <= r_col + 1'b1;
            end
            if (i_cmd_bus.emit) begin
                r_emit_idx  <= r_emit_idx + 1'b1;
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.capture) begin
            r_from   <= i_from_node;
            r_to     <= i_to_node;
            r_weight <= i_weight[WEIGHT_BITS-1:0];
            r_root   <= i_root_node;
        end
        if (i_cmd_bus.init) begin
            if (root_ok) begin
                r_dist[r_root[NODE_W-1:0]] <= '0;
                r_fifo[0]                  <= r_root[NODE_W-1:0];
            end
        end else if (hit) begin
            r_dist[r_eval_col]   <= new_dist;
            r_parent[r_eval_col] <= r_cur;
            if (enq_ok) begin
                r_fifo[r_tail[NODE_W-1:0]] <= r_eval_col;
            end
        end
        if (i_cmd_bus.deq) begin
            r_cur  <= head_node;
            r_base <= rd_dist;
        end
        if (i_cmd_bus.scan) begin
            r_eval_col <= r_col;
        end
        if (i_cmd_bus.emit) begin
            o_node_id    <= NODE_FIELD_W'(r_emit_idx);
            o_reached    <= r_reached[r_emit_idx];
            o_distance   <= r_reached[r_emit_idx] ? rd_dist : '0;
            o_has_parent <= emit_hp;
            o_parent     <= emit_hp ? NODE_FIELD_W'(r_parent[r_emit_idx]) : '0;
            o_last       <= (r_emit_idx == NODE_W'(NODES - 1));
        end
    end

endmodule

`default_nettype wire

@@ design/bfs_adjacency_matrix.sv @@
// ----------------------------------------------------------------------------
// bfs_adjacency_matrix
// Breadth-first search over a weighted adjacency matrix held in RAM.
//
//   channel   direction   handshake                    payload
//   in        into block  i_in_valid / o_in_ready      cmd, from/to node, weight, root
//   out       from block  o_out_valid / i_out_ready    node_id, reached, distance,
//                                                      has_parent, parent, last
//
// A load transaction is an accept followed by one RAM write per direction.
// A search scans one matrix row per dequeued node through the single read port
// of the matrix RAM, then emits one report for every node.
// After reset a clearing pass zeroes all 256 matrix cells with o_in_ready low.
// Results leave through an output register; emission stalls while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bfs_adjacency_matrix_macros.svh"

module bfs_adjacency_matrix (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_cmd,
    input  wire logic [bfs_pkg::NODE_FIELD_W-1:0]     i_from_node,
    input  wire logic [bfs_pkg::NODE_FIELD_W-1:0]     i_to_node,
    input  wire logic [bfs_pkg::WEIGHT_FIELD_W-1:0]   i_weight,
    input  wire logic [bfs_pkg::NODE_FIELD_W-1:0]     i_root_node,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic      [bfs_pkg::NODE_FIELD_W-1:0]     o_node_id,
    output logic                                      o_reached,
    output logic      [bfs_pkg::DIST_W-1:0]           o_distance,
    output logic                                      o_has_parent,
    output logic      [bfs_pkg::NODE_FIELD_W-1:0]     o_parent,
    output logic                                      o_last
);

    import bfs_pkg::*;

    t_cmd  cmd_bus;
    t_stat stat_bus;

    bfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_stat     (stat_bus),
        .o_cmd      (cmd_bus)
    );

    bfs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_bus    (cmd_bus),
        .o_stat       (stat_bus),
        .i_from_node  (i_from_node),
        .i_to_node    (i_to_node),
        .i_weight     (i_weight),
        .i_root_node  (i_root_node),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_node_id    (o_node_id),
        .o_reached    (o_reached),
        .o_distance   (o_distance),
        .o_has_parent (o_has_parent),
        .o_parent     (o_parent),
        .o_last       (o_last)
    );

    `BFS_ASSERT_IMPLIES(a_no_accept_in_clear, i_clk, i_rst_n, cmd_bus.clr_step, !o_in_ready)
    `BFS_ASSERT_IMPLIES(a_deq_needs_entry, i_clk, i_rst_n, cmd_bus.deq, stat_bus.q_ready)
    `BFS_ASSERT_NEXT(a_emit_fills_out, i_clk, i_rst_n, cmd_bus.emit, o_out_valid)

endmodule

`default_nettype wire

@@ bench/bfs_adjacency_matrix_test.sv @@
// ----------------------------------------------------------------------------
// bfs_adjacency_matrix_test
// Self-checking bench for the breadth-first search block. Edge writes and
// searches go in through the input channel with random gaps. A local copy of
// the weight matrix predicts the per-node report of every search. Each report
// is compared field by field as it leaves, under random output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_adjacency_matrix_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bfs_pkg::*;

    localparam int          RANDOM_ITEMS  = 375;
    localparam int          DRAIN_EVERY   = 60;
    localparam int          SETTLE_CYCLES = 32;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    localparam logic [WEIGHT_FIELD_W-1:0] WEIGHT_MASK =
        WEIGHT_FIELD_W'((1 << WEIGHT_BITS) - 1);

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] node_id;
        logic                    reached;
        logic [DIST_W-1:0]       distance;
        logic                    has_parent;
        logic [NODE_FIELD_W-1:0] parent;
        logic                    last;
    } node_report_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      i_cmd = OP_LOAD;
    logic [NODE_FIELD_W-1:0]   i_from_node = '0;
    logic [NODE_FIELD_W-1:0]   i_to_node = '0;
    logic [WEIGHT_FIELD_W-1:0] i_weight = '0;
    logic [NODE_FIELD_W-1:0]   i_root_node = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [NODE_FIELD_W-1:0]   o_node_id;
    logic                      o_reached;
    logic [DIST_W-1:0]         o_distance;
    logic                      o_has_parent;
    logic [NODE_FIELD_W-1:0]   o_parent;
    logic                      o_last;

    logic [WEIGHT_FIELD_W-1:0] link_weight [NODES][NODES];
    node_report_t              pending_node_reports [$];
    bit                        steady_flow = 1'b0;
    bit                        mismatch_seen = 1'b0;
    int unsigned               cycle_count = 0;

    bfs_adjacency_matrix u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_from_node  (i_from_node),
        .i_to_node    (i_to_node),
        .i_weight     (i_weight),
        .i_root_node  (i_root_node),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_node_id    (o_node_id),
        .o_reached    (o_reached),
        .o_distance   (o_distance),
        .o_has_parent (o_has_parent),
        .o_parent     (o_parent),
        .o_last       (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void store_link(input logic [NODE_FIELD_W-1:0] a,
                                       input logic [NODE_FIELD_W-1:0] b,
                                       input logic [WEIGHT_FIELD_W-1:0] w);
        if (int'(a) < NODES && int'(b) < NODES) begin
            link_weight[a][b] = w & WEIGHT_MASK;
            link_weight[b][a] = w & WEIGHT_MASK;
        end
    endfunction

    function automatic void predict_search_tree(input logic [NODE_FIELD_W-1:0] root);
        logic [DIST_W-1:0]       node_dist [NODES];
        logic                    seen [NODES];
        logic [NODE_FIELD_W-1:0] pred [NODES];
        logic                    has_pred [NODES];
        logic [NODE_FIELD_W-1:0] visit [NODES];
        int                      head;
        int                      tail;
        int                      cur;
        logic [DIST_W:0]         sum;
        node_report_t            rpt;
        for (int n = 0; n < NODES; n++) begin
            node_dist[n] = '0;
            seen[n] = 1'b0;
            pred[n] = '0;
            has_pred[n] = 1'b0;
            visit[n] = '0;
        end
        head = 0;
        tail = 0;
        if (int'(root) < NODES) begin
            seen[root] = 1'b1;
            visit[tail] = root;
            tail++;
        end
        while (head < tail && head < NODES) begin
            cur = int'(visit[head]);
            head++;
            for (int n = 0; n < NODES; n++) begin
                if (link_weight[cur][n] != '0 && !seen[n]) begin
                    sum = {1'b0, node_dist[cur]} + (DIST_W + 1)'(link_weight[cur][n]);
                    node_dist[n] = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
                    seen[n] = 1'b1;
                    pred[n] = NODE_FIELD_W'(cur);
                    has_pred[n] = 1'b1;
                    if (tail < NODES) begin
                        visit[tail] = NODE_FIELD_W'(n);
                        tail++;
                    end
                end
            end
        end
        for (int n = 0; n < NODES; n++) begin
            rpt.node_id    = NODE_FIELD_W'(n);
            rpt.reached    = seen[n];
            rpt.distance   = seen[n] ? node_dist[n] : '0;
            rpt.has_parent = seen[n] && has_pred[n];
            rpt.parent     = (seen[n] && has_pred[n]) ? pred[n] : '0;
            rpt.last       = (n == NODES - 1);
            pending_node_reports.push_back(rpt);
        end
    endfunction

    task automatic issue_command(input logic c,
                                 input logic [NODE_FIELD_W-1:0] from_n,
                                 input logic [NODE_FIELD_W-1:0] to_n,
                                 input logic [WEIGHT_FIELD_W-1:0] w,
                                 input logic [NODE_FIELD_W-1:0] root);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= c;
        i_from_node <= from_n;
        i_to_node   <= to_n;
        i_weight    <= w;
        i_root_node <= root;
        do @(posedge i_clk); while (!o_in_ready);
        if (c == OP_LOAD)
            store_link(from_n, to_n, w);
        else
            predict_search_tree(root);
    endtask

    task automatic load_link(input logic [NODE_FIELD_W-1:0] a,
                             input logic [NODE_FIELD_W-1:0] b,
                             input logic [WEIGHT_FIELD_W-1:0] w);
        issue_command(OP_LOAD, a, b, w, NODE_FIELD_W'($urandom));
    endtask

    task automatic search_from(input logic [NODE_FIELD_W-1:0] root);
        issue_command(OP_SEARCH, NODE_FIELD_W'($urandom), NODE_FIELD_W'($urandom),
                      WEIGHT_FIELD_W'($urandom), root);
    endtask

    task automatic hold_until_reports_drained(input int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_node_reports.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [WEIGHT_FIELD_W-1:0] draw_weight();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 7)
            return '0;
        if (pick < 10)
            return '1;
        if (pick < 12)
            return WEIGHT_FIELD_W'(1);
        return WEIGHT_FIELD_W'($urandom_range(1, 255));
    endfunction

    always begin
        int stall;
        stall = steady_flow ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
            @(negedge i_clk);
            i_out_ready <= 1'b0;
            repeat (stall - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_out_ready <= 1'b1;
        do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
    end

    task automatic compare_field(input string name, input int unsigned exp_val,
                                 input int unsigned act_val);
        if (exp_val !== act_val) begin
            $error("%s expected %0d got %0d", name, exp_val, act_val);
            mismatch_seen = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        node_report_t exp_rpt;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_node_reports.size() == 0) begin
                $error("unexpected report for node %0d", o_node_id);
                mismatch_seen = 1'b1;
            end else begin
                exp_rpt = pending_node_reports.pop_front();
                compare_field("node_id", exp_rpt.node_id, o_node_id);
                compare_field("reached", exp_rpt.reached, o_reached);
                compare_field("distance", exp_rpt.distance, o_distance);
                compare_field("has_parent", exp_rpt.has_parent, o_has_parent);
                compare_field("parent", exp_rpt.parent, o_parent);
                compare_field("last", exp_rpt.last, o_last);
            end
        end
    end

    task automatic test_empty_matrix();
        search_from(NODE_FIELD_W'(0));
    endtask

    task automatic test_long_chain();
        for (int k = 0; k < NODES - 1; k++)
            load_link(NODE_FIELD_W'(k), NODE_FIELD_W'(k + 1), '1);
        search_from(NODE_FIELD_W'(0));
        search_from(NODE_FIELD_W'(NODES - 1));
    endtask

    task automatic test_edge_updates();
        load_link(NODE_FIELD_W'(3), NODE_FIELD_W'(4), '0);
        load_link(NODE_FIELD_W'(0), NODE_FIELD_W'(15), 8'h55);
        load_link(NODE_FIELD_W'(9), NODE_FIELD_W'(9), WEIGHT_FIELD_W'(1));
        load_link(NODE_FIELD_W'(12), NODE_FIELD_W'(11), 8'hAA);
        search_from(NODE_FIELD_W'(0));
        search_from(NODE_FIELD_W'(9));
    endtask

    task automatic test_random_traffic();
        int sent;
        int since_drain;
        int burst;
        bit prune;
        sent = 0;
        since_drain = 0;
        while (sent < RANDOM_ITEMS) begin
            steady_flow = ($urandom_range(0, 5) == 0);
            prune = ($urandom_range(0, 7) == 0);
            burst = prune ? $urandom_range(4, 10) : $urandom_range(0, 6);
            repeat (burst) begin
                load_link(NODE_FIELD_W'($urandom), NODE_FIELD_W'($urandom),
                          prune ? '0 : draw_weight());
                sent++;
            end
            search_from(NODE_FIELD_W'($urandom));
            sent++;
            since_drain += burst + 1;
            if (since_drain >= DRAIN_EVERY) begin
                hold_until_reports_drained(0);
                since_drain = 0;
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        for (int a = 0; a < NODES; a++)
            for (int b = 0; b < NODES; b++)
                link_weight[a][b] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_matrix();
        test_long_chain();
        test_edge_updates();
        test_random_traffic();

        hold_until_reports_drained(SETTLE_CYCLES);
        if (!mismatch_seen)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ bfs_adjacency_matrix.f @@
+incdir+design
design/bfs_pkg.sv
design/bfs_ram.sv
design/bfs_ctrl.sv
design/bfs_dp.sv
design/bfs_adjacency_matrix.sv
bench/bfs_adjacency_matrix_test.sv
